// File: hdl/cls_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// cls_pkg
// Types and codes shared by the circular list store controller and datapath.
// ============================================================================
package cls_pkg;

    localparam int IDX_W   = 8;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 9;

    localparam logic [2:0] ACT_APPEND   = 3'd0;
    localparam logic [2:0] ACT_ROT_FWD  = 3'd1;
    localparam logic [2:0] ACT_ROT_BACK = 3'd2;
    localparam logic [2:0] ACT_SWAP     = 3'd3;
    localparam logic [2:0] ACT_READ     = 3'd4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef struct packed {
        logic [2:0]              action;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]        index_a;
        logic [IDX_W-1:0]        index_b;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]              status;
        logic [COUNT_W-1:0]      entry_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic    capture;
        logic    walk_start;
        logic    walk_sel_b;
        logic    walk_step;
        logic    lat_a;
        logic    lat_b;
        logic    prv_rd;
        logic    rot_rd;
        logic    head_load;
        logic    head_fwd;
        logic    app_w1;
        logic    app_w2;
        logic    val_rd;
        logic    val_rd_sel_b;
        logic    tmp_load;
        logic    swp_w1;
        logic    swp_w2;
        logic    out_load;
        status_t status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] action;
        logic       count_zero;
        logic       count_full;
        logic       ia_bad;
        logic       ib_bad;
        logic       walk_done;
        logic       out_free;
    } sts_t;

endpackage

// File: hdl/cls_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// cls_datapath
// Slot RAMs (value, next, prev), head and count registers, link walker and
// result register.
// ============================================================================
module cls_datapath #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  cls_pkg::req_t  s_data,
    input  cls_pkg::cmd_t  cmd,
    output cls_pkg::sts_t  sts,
    output logic           m_valid,
    input  logic           m_ready,
    output cls_pkg::rsp_t  m_data
);
    import cls_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [VALUE_BITS-1:0] val_mem [CAPACITY];
    logic [SLOT_W-1:0]     nxt_mem [CAPACITY];
    logic [SLOT_W-1:0]     prv_mem [CAPACITY];

    logic [VALUE_BITS-1:0] val_rdata;
    logic [SLOT_W-1:0]     nxt_rdata;
    logic [SLOT_W-1:0]     prv_rdata;

    req_t                  req_reg;
    rsp_t                  rsp_reg;
    logic                  m_valid_reg;
    logic [SLOT_W-1:0]     head_reg;
    logic [CNT_W-1:0]      count_reg;
    logic                  walk_mem_reg;
    logic [IDX_W-1:0]      steps_reg;
    logic [SLOT_W-1:0]     sa_reg;
    logic [SLOT_W-1:0]     sb_reg;
    logic [VALUE_BITS-1:0] tmp_reg;

    logic [SLOT_W-1:0]     walk_cur;
    logic [SLOT_W-1:0]     new_slot;
    logic [SLOT_W-1:0]     tail;
    logic [IDX_W-1:0]      pos_a;
    logic [VALUE_BITS-1:0] new_val;
    rsp_t                  rsp_next;

    logic                  val_we;
    logic [SLOT_W-1:0]     val_wa;
    logic [VALUE_BITS-1:0] val_wd;
    logic [SLOT_W-1:0]     val_ra;
    logic                  nxt_we;
    logic [SLOT_W-1:0]     nxt_wa;
    logic [SLOT_W-1:0]     nxt_wd;
    logic                  nxt_re;
    logic [SLOT_W-1:0]     nxt_ra;
    logic                  prv_we;
    logic [SLOT_W-1:0]     prv_wa;
    logic [SLOT_W-1:0]     prv_wd;
    logic                  prv_re;

    assign sts.action     = req_reg.action;
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_full = (count_reg == CNT_W'(CAPACITY));
    assign sts.ia_bad     = (CMP_W'(req_reg.index_a) >= CMP_W'(count_reg));
    assign sts.ib_bad     = (CMP_W'(req_reg.index_b) >= CMP_W'(count_reg));
    assign sts.walk_done  = (steps_reg == '0);
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign walk_cur = walk_mem_reg ? nxt_rdata : head_reg;
    assign new_slot = SLOT_W'(count_reg);
    assign tail     = sts.count_zero ? '0 : prv_rdata;
    assign pos_a    = sts.ia_bad ? '0 : req_reg.index_a;
    assign new_val  = VALUE_BITS'(req_reg.value);

    always_comb begin
        val_we = cmd.app_w1 || cmd.swp_w1 || cmd.swp_w2;
        val_wa = new_slot;
        val_wd = new_val;
        if (cmd.swp_w1) begin
            val_wa = sa_reg;
            val_wd = val_rdata;
        end else if (cmd.swp_w2) begin
            val_wa = sb_reg;
            val_wd = tmp_reg;
        end
        val_ra = cmd.val_rd_sel_b ? sb_reg : sa_reg;

        nxt_we = cmd.app_w1 || cmd.app_w2;
        nxt_wa = cmd.app_w1 ? tail : new_slot;
        nxt_wd = cmd.app_w1 ? new_slot : head_reg;
        nxt_re = cmd.walk_step || cmd.rot_rd;
        nxt_ra = cmd.rot_rd ? head_reg : walk_cur;

        prv_we = cmd.app_w1 || cmd.app_w2;
        prv_wa = cmd.app_w1 ? new_slot : head_reg;
        prv_wd = cmd.app_w1 ? tail : new_slot;
        prv_re = cmd.prv_rd || cmd.rot_rd;
    end

    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_wa] <= val_wd;
        end
        if (cmd.val_rd) begin
            val_rdata <= val_mem[val_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (nxt_we) begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
        if (nxt_re) begin
            nxt_rdata <= nxt_mem[nxt_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (prv_we) begin
            prv_mem[prv_wa] <= prv_wd;
        end
        if (prv_re) begin
            prv_rdata <= prv_mem[head_reg];
        end
    end

    always_comb begin
        rsp_next.read_value = '0;
        if (req_reg.action == ACT_READ && !sts.count_zero) begin
            rsp_next.read_value = DATA_W'(val_rdata);
        end
        rsp_next.status      = cmd.status;
        rsp_next.entry_count = COUNT_W'(count_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
            walk_mem_reg <= 1'b0;
        end else begin
            if (cmd.head_load) begin
                head_reg <= cmd.head_fwd ? nxt_rdata : prv_rdata;
            end
            if (cmd.app_w2) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.walk_start) begin
                walk_mem_reg <= 1'b0;
            end else if (cmd.walk_step) begin
                walk_mem_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_data;
        end
        if (cmd.walk_start) begin
            steps_reg <= cmd.walk_sel_b ? req_reg.index_b : pos_a;
        end else if (cmd.walk_step) begin
            steps_reg <= steps_reg - 1'b1;
        end
        if (cmd.lat_a) begin
            sa_reg <= walk_cur;
        end
        if (cmd.lat_b) begin
            sb_reg <= walk_cur;
        end
        if (cmd.tmp_load) begin
            tmp_reg <= val_rdata;
        end
        if (cmd.out_load) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = rsp_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1))
        else $error("entry count moved by other than one");

    a_head_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.head_load |=> $stable(head_reg))
        else $error("head moved without a rotate");

endmodule

// File: hdl/cls_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// cls_ctrl
// Request sequencer: decodes the action and steps the datapath through
// walks, slot RAM reads and writes, and the result load.
// ============================================================================
module cls_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cls_pkg::sts_t sts,
    output cls_pkg::cmd_t cmd
);
    import cls_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_APP_RD,
        S_APP_W1,
        S_APP_W2,
        S_ROT_RD,
        S_ROT_UPD,
        S_WALK_A,
        S_WALK_B,
        S_RD_VAL,
        S_SWP_RDA,
        S_SWP_RDB,
        S_SWP_W1,
        S_SWP_W2,
        S_RESP
    } state_t;

    state_t  state_reg, state_next;
    status_t st_reg, st_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.status = st_reg;
        state_next = state_reg;
        st_next    = st_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    st_next     = ST_OK;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (sts.action)
                    ACT_APPEND: begin
                        if (sts.count_full) begin
                            st_next    = ST_FULL;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_APP_RD;
                        end
                    end
                    ACT_ROT_FWD, ACT_ROT_BACK: begin
                        if (sts.count_zero) begin
                            st_next    = ST_EMPTY;
                            state_next = S_RESP;
                        end else begin
                            state_next = S_ROT_RD;
                        end
                    end
                    ACT_SWAP: begin
                        if (sts.ia_bad || sts.ib_bad) begin
                            st_next    = ST_RANGE;
                            state_next = S_RESP;
                        end else begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK_A;
                        end
                    end
                    ACT_READ: begin
                        if (sts.ia_bad) begin
                            st_next = ST_RANGE;
                        end
                        if (sts.count_zero) begin
                            state_next = S_RESP;
                        end else begin
                            cmd.walk_start = 1'b1;
                            state_next     = S_WALK_A;
                        end
                    end
                    default: begin
                        st_next    = ST_RANGE;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_APP_RD: begin
                cmd.prv_rd = 1'b1;
                state_next = S_APP_W1;
            end
            S_APP_W1: begin
                cmd.app_w1 = 1'b1;
                state_next = S_APP_W2;
            end
            S_APP_W2: begin
                cmd.app_w2 = 1'b1;
                state_next = S_RESP;
            end
            S_ROT_RD: begin
                cmd.rot_rd = 1'b1;
                state_next = S_ROT_UPD;
            end
            S_ROT_UPD: begin
                cmd.head_load = 1'b1;
                cmd.head_fwd  = (sts.action == ACT_ROT_FWD);
                state_next    = S_RESP;
            end
            S_WALK_A: begin
                if (sts.walk_done) begin
                    cmd.lat_a = 1'b1;
                    if (sts.action == ACT_SWAP) begin
                        cmd.walk_start = 1'b1;
                        cmd.walk_sel_b = 1'b1;
                        state_next     = S_WALK_B;
                    end else begin
                        state_next = S_RD_VAL;
                    end
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_WALK_B: begin
                if (sts.walk_done) begin
                    cmd.lat_b  = 1'b1;
                    state_next = S_SWP_RDA;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            S_RD_VAL: begin
                cmd.val_rd = 1'b1;
                state_next = S_RESP;
            end
            S_SWP_RDA: begin
                cmd.val_rd = 1'b1;
                state_next = S_SWP_RDB;
            end
            S_SWP_RDB: begin
                cmd.val_rd       = 1'b1;
                cmd.val_rd_sel_b = 1'b1;
                cmd.tmp_load     = 1'b1;
                state_next       = S_SWP_W1;
            end
            S_SWP_W1: begin
                cmd.swp_w1 = 1'b1;
                state_next = S_SWP_W2;
            end
            S_SWP_W2: begin
                cmd.swp_w2 = 1'b1;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            st_reg    <= ST_OK;
        end else begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DISPATCH)
        else $error("accepted request not dispatched");

    a_step_not_done: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> !sts.walk_done)
        else $error("walk stepped past its position");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

endmodule

// File: hdl/circular_list_store.sv
`timescale 1ns / 1ps
// ============================================================================
// circular_list_store
// Fixed-capacity circular doubly linked list with a rotating head.
// ============================================================================
// One request at a time; a finished result waits in the output register while
// the next request is taken. An out-of-range read of a non-empty list returns
// the head's value. The walk to a position reads the next-link RAM once per
// step, so reads and swaps grow with the requested positions.
// ============================================================================
module circular_list_store #(
    parameter int CAPACITY   = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  cls_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cls_pkg::rsp_t m_data
);
    import cls_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cls_datapath #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: test/circular_list_store_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// circular_list_store_tb
// Self-checking bench for the circular list store. It sends directed and
// random list requests, predicts each response in a scoreboard model of the
// list, and compares the responses field by field under varying idle and
// stall patterns.
// ============================================================================
import cls_pkg::*;

class list_scoreboard;
    localparam int CAPACITY = 256;

    logic [DATA_W-1:0] slot_val [CAPACITY];
    logic [IDX_W-1:0]  slot_nxt [CAPACITY];
    logic [IDX_W-1:0]  slot_prv [CAPACITY];
    logic [IDX_W-1:0]  head = '0;
    int unsigned       entries = 0;
    rsp_t              pending [$];
    int                errors = 0;

    task report_mismatch(string what);
        $display("ERROR at %0t: %s", $realtime, what);
        errors++;
    endtask

    function logic [IDX_W-1:0] walk_to(int unsigned pos);
        logic [IDX_W-1:0] s;
        s = head;
        for (int unsigned k = 0; k < pos; k++) s = slot_nxt[s];
        return s;
    endfunction

    function void note_request(req_t r);
        rsp_t              e;
        logic [IDX_W-1:0]  ns;
        logic [IDX_W-1:0]  t;
        logic [IDX_W-1:0]  sa;
        logic [IDX_W-1:0]  sb;
        logic [DATA_W-1:0] tmp;
        e.read_value = '0;
        e.status = ST_OK;
        case (r.action)
            ACT_APPEND: begin
                if (entries >= CAPACITY) begin
                    e.status = ST_FULL;
                end else if (entries == 0) begin
                    slot_val[0] = r.value;
                    slot_nxt[0] = '0;
                    slot_prv[0] = '0;
                    head = '0;
                    entries = 1;
                end else begin
                    ns = IDX_W'(entries);
                    t = slot_prv[head];
                    slot_val[ns] = r.value;
                    slot_nxt[t] = ns;
                    slot_prv[ns] = t;
                    slot_nxt[ns] = head;
                    slot_prv[head] = ns;
                    entries++;
                end
            end
            ACT_ROT_FWD: begin
                if (entries == 0) e.status = ST_EMPTY;
                else head = slot_nxt[head];
            end
            ACT_ROT_BACK: begin
                if (entries == 0) e.status = ST_EMPTY;
                else head = slot_prv[head];
            end
            ACT_SWAP: begin
                if (r.index_a >= entries || r.index_b >= entries) begin
                    e.status = ST_RANGE;
                end else begin
                    sa = walk_to(r.index_a);
                    sb = walk_to(r.index_b);
                    tmp = slot_val[sa];
                    slot_val[sa] = slot_val[sb];
                    slot_val[sb] = tmp;
                end
            end
            ACT_READ: begin
                if (r.index_a >= entries) begin
                    e.status = ST_RANGE;
                    if (entries != 0) e.read_value = slot_val[head];
                end else begin
                    e.read_value = slot_val[walk_to(r.index_a)];
                end
            end
            default: e.status = ST_RANGE;
        endcase
        e.entry_count = COUNT_W'(entries);
        pending.push_back(e);
    endfunction

    task check_response(rsp_t got);
        rsp_t e;
        if (pending.size() == 0) begin
            report_mismatch("response with no request outstanding");
        end else begin
            e = pending.pop_front();
            if (got.read_value !== e.read_value)
                report_mismatch($sformatf("read_value %h, expected %h",
                                          got.read_value, e.read_value));
            if (got.status !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, e.status));
            if (got.entry_count !== e.entry_count)
                report_mismatch($sformatf("entry_count %0d, expected %0d",
                                          got.entry_count, e.entry_count));
        end
    endtask
endclass

module circular_list_store_tb;
    localparam int CAPACITY     = 256;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 600;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    list_scoreboard sb;
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    int list_len = 0;
    int quiet_cycles = 0;

    circular_list_store dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) sb.check_response(m_data);
            if (s_valid && s_ready) sb.note_request(s_data);
            if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic req_t make_request(logic [2:0] action, logic [DATA_W-1:0] value,
                                          logic [IDX_W-1:0] ia, logic [IDX_W-1:0] ib);
        req_t r;
        r.action = action;
        r.value = value;
        r.index_a = ia;
        r.index_b = ib;
        return r;
    endfunction

    task automatic send_request(req_t r);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (r.action == ACT_APPEND && list_len < CAPACITY) list_len++;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        if (list_len > 0 && $urandom_range(9) < 8)
            return IDX_W'($urandom_range(list_len - 1));
        return IDX_W'($urandom_range(255));
    endfunction

    initial begin
        req_t r;
        int   roll;
        int   append_pct;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty list, single entry, value extremes, bad indexes, unused action codes
        send_request(make_request(ACT_READ, 32'h1234_5678, 8'd0, 8'd0));
        send_request(make_request(ACT_READ, 32'h0, 8'd255, 8'd255));
        send_request(make_request(ACT_ROT_FWD, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_ROT_BACK, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_SWAP, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_APPEND, 32'h7FFF_FFFF, 8'd0, 8'd0));
        send_request(make_request(ACT_READ, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_ROT_FWD, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_ROT_BACK, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_APPEND, 32'h8000_0000, 8'd255, 8'd255));
        send_request(make_request(ACT_APPEND, 32'h0000_0000, 8'd0, 8'd0));
        send_request(make_request(ACT_APPEND, 32'hFFFF_FFFF, 8'd0, 8'd0));
        send_request(make_request(ACT_READ, 32'h0, 8'd3, 8'd0));
        send_request(make_request(ACT_READ, 32'h0, 8'd4, 8'd0));
        send_request(make_request(ACT_READ, 32'h0, 8'd255, 8'd0));
        send_request(make_request(ACT_SWAP, 32'h0, 8'd0, 8'd3));
        send_request(make_request(ACT_SWAP, 32'h0, 8'd1, 8'd1));
        send_request(make_request(ACT_SWAP, 32'h0, 8'd4, 8'd0));
        send_request(make_request(ACT_SWAP, 32'h0, 8'd0, 8'd255));
        send_request(make_request(ACT_ROT_FWD, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_READ, 32'h0, 8'd0, 8'd0));
        send_request(make_request(ACT_ROT_BACK, 32'h0, 8'd0, 8'd0));
        for (int c = 5; c <= 7; c++)
            send_request(make_request(3'(c), $urandom, 8'($urandom), 8'($urandom)));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            case ((i / 100) % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin src_idle_pct = 6; sink_stall_pct = 6; end
            endcase
            append_pct = (list_len < CAPACITY) ? 35 : 10;
            roll = $urandom_range(99);
            r.value = $urandom;
            r.index_a = pick_index();
            r.index_b = pick_index();
            if (roll < append_pct) r.action = ACT_APPEND;
            else if (roll < append_pct + 28) r.action = ACT_READ;
            else if (roll < append_pct + 44) r.action = ACT_SWAP;
            else if (roll < append_pct + 52) r.action = ACT_ROT_FWD;
            else if (roll < append_pct + 60) r.action = ACT_ROT_BACK;
            else if (roll < 96) r.action = ACT_READ;
            else r.action = 3'($urandom_range(5, 7));
            send_request(r);
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/cls_pkg.sv
hdl/cls_datapath.sv
hdl/cls_ctrl.sv
hdl/circular_list_store.sv
test/circular_list_store_tb.sv
